### sv/ppqs_pkg.sv
package ppqs_pkg;

    // Defaults and fixed layout
    localparam int MAX_TASKS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [7:0] QUANTUM_RST = 8'd2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Input tdata layout
    localparam int S_ID_LSB   = 0;
    localparam int S_PRIO_LSB = 8;
    localparam int S_RT_LSB   = 12;

    // Output tdata layout
    localparam int M_ACC_BIT  = 0;
    localparam int M_BUSY_BIT = 1;
    localparam int M_ID_LSB   = 2;
    localparam int M_FIN_BIT  = 10;
    localparam int M_TURN_LSB = 11;

    typedef enum logic {
        KIND_ARRIVAL = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  task_id;
        logic [3:0]  prio;
        logic [15:0] run_time;
    } req_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [3:0]  prio;
        logic [15:0] remaining;
        logic [31:0] ready_time;
        logic [31:0] arrived_time;
        logic        ahead;
    } slot_ent_t;

    typedef struct packed {
        kind_t       kind;
        logic        accepted;
        logic        busy;
        logic [7:0]  run_id;
        logic        finished;
        logic [31:0] turnaround;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE_SCAN,
        ST_SEL_SCAN,
        ST_RUN,
        ST_DONE
    } eng_state_t;

    // a preferred over b; full tie keeps b (the earlier slot)
    function automatic logic outranks(slot_ent_t a, slot_ent_t b);
        logic r;
        if (a.prio != b.prio) begin
            r = (a.prio > b.prio);
        end else if (a.ready_time != b.ready_time) begin
            r = (a.ready_time < b.ready_time);
        end else begin
            r = a.ahead && !b.ahead;
        end
        return r;
    endfunction

endpackage

### sv/ppqs_front.sv
module ppqs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ppqs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ppqs_pkg::req_t                push_req
);
    import ppqs_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    req_t hold_req_reg, hold_req_next;

    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_req   = hold_req_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_req_next   = hold_req_reg;
        if (hold_valid_reg && push_ready) begin
            hold_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            hold_valid_next        = 1'b1;
            hold_req_next.kind     = kind_t'(s_tuser);
            hold_req_next.task_id  = s_tdata[S_ID_LSB +: 8];
            hold_req_next.prio     = s_tdata[S_PRIO_LSB +: 4];
            hold_req_next.run_time = s_tdata[S_RT_LSB +: 16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_req_reg <= hold_req_next;
    end

endmodule

### sv/ppqs_fifo.sv
module ppqs_fifo #(
    parameter int DEPTH = ppqs_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ppqs_pkg::req_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ppqs_pkg::req_t rd_data
);
    import ppqs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/ppqs_engine.sv
module ppqs_engine #(
    parameter int MAX_TASKS = ppqs_pkg::MAX_TASKS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata,
    input  logic           q_valid,
    output logic           q_ready,
    input  ppqs_pkg::req_t q_req,
    output logic           res_valid,
    input  logic           res_ready,
    output ppqs_pkg::res_t res
);
    import ppqs_pkg::*;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    eng_state_t state_reg, state_next;

    logic [7:0]            quantum_reg;
    logic [31:0]           now_reg, now_next;
    logic [MAX_TASKS-1:0]  valid_reg, valid_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic                  held_reg, held_next;
    logic [7:0]            slice_reg, slice_next;
    logic                  higher_reg, higher_next;
    slot_ent_t             cur_ent_reg, cur_ent_next;
    req_t                  req_reg, req_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  rd_live_reg, rd_live_next;
    logic [SLOT_W-1:0]     rd_slot_reg;
    logic                  best_found_reg, best_found_next;
    logic [SLOT_W-1:0]     best_slot_reg, best_slot_next;
    slot_ent_t             best_ent_reg, best_ent_next;
    res_t                  res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;

    // Slot table: one write port, one registered read port
    slot_ent_t             slot_mem [MAX_TASKS];
    slot_ent_t             mem_rdata_reg;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    slot_ent_t             mem_wdata;
    logic [SLOT_W-1:0]     mem_raddr;

    logic                  put_back;
    logic                  cand_ok;
    logic                  out_free;
    logic [SLOT_W-1:0]     free_idx;

    assign mem_raddr = cnt_reg[SLOT_W-1:0];
    assign free_idx  = cnt_reg[SLOT_W-1:0];
    assign cand_ok   = rd_live_reg && valid_reg[rd_slot_reg];
    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        cur_slot_next   = cur_slot_reg;
        held_next       = held_reg;
        slice_next      = slice_reg;
        higher_next     = higher_reg;
        cur_ent_next    = cur_ent_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        rd_live_next    = 1'b0;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_ent_next   = best_ent_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_slot_reg;
        mem_wdata       = cur_ent_reg;
        q_ready         = 1'b0;
        put_back        = 1'b0;

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_ready  = 1'b1;
                    req_next = q_req;
                    cnt_next = '0;
                    if (q_req.kind == KIND_TICK) begin
                        higher_next = 1'b0;
                        put_back    = held_reg && (higher_reg || (slice_reg >= quantum_reg));
                        if (put_back) begin
                            mem_we               = 1'b1;
                            mem_waddr            = cur_slot_reg;
                            mem_wdata            = cur_ent_reg;
                            mem_wdata.ready_time = now_reg;
                            mem_wdata.ahead      = 1'b0;
                            held_next            = 1'b0;
                        end
                        if (held_reg && !put_back) begin
                            state_next = ST_RUN;
                        end else begin
                            best_found_next = 1'b0;
                            state_next      = ST_SEL_SCAN;
                        end
                    end else begin
                        state_next = ST_FREE_SCAN;
                    end
                end
            end

            ST_FREE_SCAN: begin
                if (!valid_reg[free_idx]) begin
                    mem_we                 = 1'b1;
                    mem_waddr              = free_idx;
                    mem_wdata.task_id      = req_reg.task_id;
                    mem_wdata.prio         = req_reg.prio;
                    mem_wdata.remaining    = req_reg.run_time;
                    mem_wdata.ready_time   = now_reg;
                    mem_wdata.arrived_time = now_reg;
                    mem_wdata.ahead        = held_reg && (req_reg.prio == cur_ent_reg.prio);
                    valid_next[free_idx]   = 1'b1;
                    if (held_reg && (req_reg.prio > cur_ent_reg.prio)) begin
                        higher_next = 1'b1;
                    end
                    res_next          = '0;
                    res_next.kind     = KIND_ARRIVAL;
                    res_next.accepted = 1'b1;
                    state_next        = ST_DONE;
                end else if (cnt_reg == CNT_W'(MAX_TASKS - 1)) begin
                    res_next      = '0;
                    res_next.kind = KIND_ARRIVAL;
                    state_next    = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_SEL_SCAN: begin
                if (cnt_reg != CNT_W'(MAX_TASKS)) begin
                    cnt_next     = cnt_reg + CNT_W'(1);
                    rd_live_next = 1'b1;
                end
                if (cand_ok && (!best_found_reg || outranks(mem_rdata_reg, best_ent_reg))) begin
                    best_found_next = 1'b1;
                    best_slot_next  = rd_slot_reg;
                    best_ent_next   = mem_rdata_reg;
                end
                if ((cnt_reg == CNT_W'(MAX_TASKS)) && !rd_live_reg) begin
                    if (best_found_reg) begin
                        held_next     = 1'b1;
                        cur_slot_next = best_slot_reg;
                        cur_ent_next  = best_ent_reg;
                        slice_next    = '0;
                    end
                    state_next = ST_RUN;
                end
            end

            ST_RUN: begin
                res_next      = '0;
                res_next.kind = KIND_TICK;
                now_next      = now_reg + 32'd1;
                if (held_reg) begin
                    res_next.busy   = 1'b1;
                    res_next.run_id = cur_ent_reg.task_id;
                    if (cur_ent_reg.remaining <= 16'd1) begin
                        valid_next[cur_slot_reg] = 1'b0;
                        held_next                = 1'b0;
                        slice_next               = '0;
                        res_next.finished        = 1'b1;
                        res_next.turnaround      = now_reg + 32'd1 - cur_ent_reg.arrived_time;
                    end else begin
                        cur_ent_next.remaining = cur_ent_reg.remaining - 16'd1;
                        if (slice_reg != 8'hFF) begin
                            slice_next = slice_reg + 8'd1;
                        end
                    end
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            quantum_reg    <= QUANTUM_RST;
            now_reg        <= '0;
            valid_reg      <= '0;
            cur_slot_reg   <= '0;
            held_reg       <= 1'b0;
            slice_reg      <= '0;
            higher_reg     <= 1'b0;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_we) begin
                quantum_reg <= cfg_wdata;
            end
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            cur_slot_reg   <= cur_slot_next;
            held_reg       <= held_next;
            slice_reg      <= slice_next;
            higher_reg     <= higher_next;
            cnt_reg        <= cnt_next;
            rd_live_reg    <= rd_live_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
        cur_ent_reg   <= cur_ent_next;
        req_reg       <= req_next;
        rd_slot_reg   <= mem_raddr;
        best_slot_reg <= best_slot_next;
        best_ent_reg  <= best_ent_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= slot_mem[mem_raddr];
    end

endmodule

### sv/preemptive_priority_quantum_scheduler_core.sv
// Preemptive priority task scheduler with a round-robin quantum. Each input
// transaction is either a task arrival (id, priority, run time), answered
// with accepted = 1 or with accepted = 0 when all MAX_TASKS slots are taken,
// or a timer tick, answered with the id of the task that ran, a finished
// flag and the turnaround (finish time minus arrival time, mod 2^32). Higher
// priority wins, then earlier ready time, then a task that arrived at the
// priority of the running task, then the lower slot. A running task goes
// back to the ready table when its quantum is used up or when a strictly
// higher-priority task arrived since its last tick. Exactly one result
// transaction per input transaction, in order. An arrival's free-slot scan
// walks the valid bits one slot a cycle, from slot 0 up to the lowest free
// slot or the last one; a tick that keeps the running task skips any scan,
// and a tick that has to pick a task walks every slot through the
// single-read-port slot table. The input register and a two-entry queue let
// transactions be taken while the scheduler is busy. The quantum register
// may only be written while no transaction is in flight; 0 behaves like 1.
module preemptive_priority_quantum_scheduler_core #(
    parameter int MAX_TASKS = ppqs_pkg::MAX_TASKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Quantum register write
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] task_id, [11:8] task_priority, [27:12] run_time, [31:28] zero
    input  logic [ppqs_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                           s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] accepted, [1] busy_res, [9:2] run_id, [10] finished,
    // [42:11] turnaround, [47:43] zero
    output logic [ppqs_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] kind
    output logic                           m_tuser
);
    import ppqs_pkg::*;

    // front -> queue
    logic push_valid, push_ready;
    req_t push_req;

    // queue -> engine
    logic q_valid, q_ready;
    req_t q_req;

    // engine result register
    res_t res;

    // Front: input register, decodes the transaction into a request
    ppqs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    // Short queue decouples request intake from the scheduling engine
    ppqs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_req),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_req)
    );

    // Back: slot table, selection scan, run/preempt bookkeeping
    ppqs_engine #(
        .MAX_TASKS (MAX_TASKS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Result packing, highest field first
    assign m_tuser = res.kind;
    assign m_tdata = {5'b0, res.turnaround, res.finished, res.run_id,
                      res.busy, res.accepted};

endmodule

### sv/ppqs_checker.sv
module ppqs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ppqs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import ppqs_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // arrival answers carry no run information
    a_arrival_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ARRIVAL) |-> (m_tdata[M_TDATA_W-1:M_BUSY_BIT] == '0))
        else $error("arrival answer with run fields set");

    // tick answers never accept; idle tick reports nothing
    a_tick_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_TICK) |->
            !m_tdata[M_ACC_BIT] &&
            (m_tdata[M_BUSY_BIT] || (m_tdata[M_TDATA_W-1:M_ID_LSB] == '0)))
        else $error("tick answer inconsistent");

    // turnaround only with completion
    a_turn_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_FIN_BIT] |-> (m_tdata[M_TURN_LSB +: 32] == '0))
        else $error("turnaround without completion");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind preemptive_priority_quantum_scheduler_core ppqs_checker u_ppqs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
